>>> hw/rtl/fpa_pkg.sv
// shared types, codes and defaults of the fork pair arbiter
package fpa_pkg;

  localparam int DEF_MAX_SEATS = 16;
  localparam int DEF_TIME_BITS = 32;

  localparam int SEAT_COUNT_W  = 5;
  localparam int THRESHOLD_W   = 32;
  localparam int IN_IDX_W      = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [SEAT_COUNT_W-1:0] RESET_SEAT_COUNT        = 5'd16;
  localparam logic [THRESHOLD_W-1:0]  RESET_FAILURE_THRESHOLD = 32'd100;

  localparam logic MODE_TAKE = 1'b0;
  localparam logic MODE_PUT  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_FREE     = 2'd0,
    RES_TAKEN    = 2'd1,
    RES_RESERVED = 2'd2
  } res_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEAT_COUNT        = 2'd0,
    CFG_FAILURE_THRESHOLD = 2'd1
  } cfg_idx_t;

endpackage

>>> hw/rtl/fork_pair_arbiter_with_aging.sv
// fork pair arbiter with aging: ring of seats sharing adjacent resources
// a take is registered at input, decided, and registered again onto the out ports
// throughput: one item per cycle, as each item updates the state read by the flag lanes
// a put gives no result; results last one cycle on out_valid and cannot be stalled
// reset (synchronous): all resources free, no failures, seat count 16, threshold 100
// failure timestamps are not cleared, they are only read while their failure is pending
module fork_pair_arbiter_with_aging
  import fpa_pkg::*;
#(
  parameter int MAX_SEATS = DEF_MAX_SEATS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [IN_IDX_W-1:0]     in_requester,
  input  logic [IN_IDX_W-1:0]     in_resource,
  input  logic [TIME_BITS-1:0]    in_time_now,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [IN_IDX_W-1:0]     out_reply_to,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int N_W   = $clog2(MAX_SEATS + 1);
  localparam int CMP_W = (N_W > SEAT_COUNT_W) ? N_W : SEAT_COUNT_W;
  localparam int DW    = (TIME_BITS > THRESHOLD_W) ? TIME_BITS : THRESHOLD_W;

  // configuration
  logic [SEAT_COUNT_W-1:0] seat_count_r;
  logic [THRESHOLD_W-1:0]  threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seat_count_r <= RESET_SEAT_COUNT;
      threshold_r  <= RESET_FAILURE_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEAT_COUNT:        seat_count_r <= cfg_data[SEAT_COUNT_W-1:0];
        CFG_FAILURE_THRESHOLD: threshold_r  <= cfg_data[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 v_r;
  logic                 mode_r;
  logic [IN_IDX_W-1:0]  req_r;
  logic [IN_IDX_W-1:0]  res_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 accept;

  // every item is settled before the next one is decided, so the next one is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      req_r  <= in_requester;
      res_r  <= in_resource;
      now_r  <= in_time_now;
    end
  end

  // state
  res_state_t           state_r [MAX_SEATS];
  res_state_t           state_nxt [MAX_SEATS];
  logic [MAX_SEATS-1:0] pend_r;
  logic [MAX_SEATS-1:0] pend_nxt;
  logic [TIME_BITS-1:0] first_r [MAX_SEATS];
  logic                 first_we;

  // ring geometry
  logic [CMP_W-1:0] n;
  logic [CMP_W-1:0] n_m1;
  logic [CMP_W-1:0] sc_ext;
  logic [CMP_W-1:0] req_ext;
  logic [CMP_W-1:0] res_ext;
  logic [CMP_W-1:0] res_inc;
  logic [CMP_W-1:0] right_ext;
  logic [CMP_W-1:0] left_ext;
  logic [IDX_W-1:0] req_i;
  logic [IDX_W-1:0] res_i;
  logic [IDX_W-1:0] right_i;
  logic [IDX_W-1:0] left_i;

  assign sc_ext = CMP_W'(seat_count_r);

  always_comb begin
    priority if (sc_ext < CMP_W'(2)) n = CMP_W'(2);
    else if (sc_ext > CMP_W'(MAX_SEATS)) n = CMP_W'(MAX_SEATS);
    else n = sc_ext;
  end

  assign n_m1      = n - CMP_W'(1);
  assign req_ext   = CMP_W'(req_r);
  assign res_ext   = CMP_W'(res_r);
  assign res_inc   = res_ext + CMP_W'(1);
  assign right_ext = (res_inc == n) ? '0 : res_inc;
  assign left_ext  = (req_ext == '0) ? n_m1 : req_ext - CMP_W'(1);
  assign req_i     = req_ext[IDX_W-1:0];
  assign res_i     = res_ext[IDX_W-1:0];
  assign right_i   = right_ext[IDX_W-1:0];
  assign left_i    = left_ext[IDX_W-1:0];

  // per-seat flag lanes, each seat compared with its ring successor
  logic [MAX_SEATS-1:0] cons;
  logic [MAX_SEATS-1:0] lt_next;
  logic [MAX_SEATS-1:0] gt_next;
  logic [MAX_SEATS-1:0] pair_free;
  logic [MAX_SEATS-1:0] reserved;

  for (genvar g = 0; g < MAX_SEATS; g++) begin : g_lane
    localparam int NX = (g == MAX_SEATS - 1) ? 0 : g + 1;
    logic                 wrap;
    logic [TIME_BITS-1:0] nb_first;
    res_state_t           nb_state;
    logic [TIME_BITS-1:0] age;

    assign wrap     = (CMP_W'(g) == n_m1);
    assign nb_first = wrap ? first_r[0] : first_r[NX];
    assign nb_state = wrap ? state_r[0] : state_r[NX];
    assign age      = now_r - first_r[g];

    // considered once strictly older than the threshold
    assign cons[g]      = pend_r[g] && (now_r > first_r[g]) && (DW'(age) > DW'(threshold_r));
    assign lt_next[g]   = first_r[g] < nb_first;
    assign gt_next[g]   = first_r[g] > nb_first;
    assign pair_free[g] = (state_r[g] == RES_FREE) && (nb_state == RES_FREE);
    assign reserved[g]  = (state_r[g] == RES_RESERVED);
  end

  // decision
  logic    take;
  logic    put;
  logic    idx_ok;
  logic    left_take;
  logic    beat_l;
  logic    beat_r;
  logic    grant_left;
  status_t status_nxt;

  assign take      = v_r && (mode_r == MODE_TAKE);
  assign put       = v_r && (mode_r == MODE_PUT);
  assign idx_ok    = (req_ext < n) && (res_ext < n);
  assign left_take = (res_r == req_r);
  // the left neighbour's successor is the requester itself
  assign beat_r     = !cons[right_i] || (cons[req_i] && lt_next[req_i]);
  assign beat_l     = !cons[left_i] || (cons[req_i] && gt_next[left_i]);
  assign grant_left = pair_free[res_i] && beat_l && beat_r;

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    first_we   = 1'b0;
    status_nxt = STATUS_ERROR;
    if (put) begin
      if (res_ext < n) state_nxt[res_i] = RES_FREE;
    end else if (take) begin
      priority if (!idx_ok) begin
        status_nxt = STATUS_ERROR;
      end else if (left_take) begin
        if (grant_left) begin
          status_nxt         = STATUS_GRANTED;
          pend_nxt[req_i]    = 1'b0;
          state_nxt[res_i]   = RES_TAKEN;
          state_nxt[right_i] = RES_RESERVED;
        end else begin
          status_nxt = STATUS_BUSY;
          // keep the first failure time on a repeated denial
          if (!pend_r[req_i]) begin
            pend_nxt[req_i] = 1'b1;
            first_we        = 1'b1;
          end
        end
      end else if (reserved[res_i]) begin
        status_nxt       = STATUS_GRANTED;
        state_nxt[res_i] = RES_TAKEN;
      end else begin
        status_nxt = STATUS_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SEATS; i++) state_r[i] <= RES_FREE;
      pend_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (first_we) first_r[req_i] <= now_r;
  end

  // result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [IN_IDX_W-1:0] out_reply_to_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status_r   <= status_nxt;
      out_reply_to_r <= req_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_reply_to = out_reply_to_r;

  a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(v_r && (mode_r == MODE_TAKE)))
    else $error("result without a take transfer");

  a_grant_clears_failure: assert property (@(posedge clk) disable iff (!rst_n)
    (take && idx_ok && left_take && grant_left) |=>
      (!pend_r[$past(req_i)] && (state_r[$past(req_i)] == RES_TAKEN)))
    else $error("left grant did not take resource or clear failure");

  a_first_time_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (take && idx_ok && left_take && !grant_left && pend_r[req_i]) |=>
      (first_r[$past(req_i)] == $past(first_r[req_i])))
    else $error("first failure time overwritten on repeated denial");

  a_bad_index_error: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !idx_ok) |=> (out_valid_r && (out_status_r == STATUS_ERROR)))
    else $error("bad index not reported as error");

endmodule
